// ===== rtl/gmn_pkg.sv =====
// ----------------------------------------------------------------------------
// gmn_pkg: shared types and constants of the grid mesh normal/index generator
// Field widths of the result stream, slot codes of the result sequencer,
// register map of the configuration port.
// ----------------------------------------------------------------------------
package gmn_pkg;

  // Fixed field widths of the result stream and the configuration registers
  localparam int NORM_W = 35;
  localparam int PT_W   = 10;
  localparam int IDX_W  = 20;
  localparam int CFG_W  = 11;

  // Configuration port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // Register indexes (paddr[2])
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  // Smallest grid dimension
  localparam int GRID_MIN = 2;

  // Result kinds
  localparam logic KIND_NORMAL = 1'b0;
  localparam logic KIND_INDEX  = 1'b1;

  // Result slots of one vertex, emitted lowest first
  localparam int NUM_SLOTS = 9;
  localparam int SLOT_W    = 4;
  localparam logic [SLOT_W-1:0] SLOT_UP      = 4'd0;
  localparam logic [SLOT_W-1:0] SLOT_LR_PREV = 4'd1;
  localparam logic [SLOT_W-1:0] SLOT_LR_CUR  = 4'd2;
  localparam logic [SLOT_W-1:0] SLOT_TRI0    = 4'd3;
  localparam logic [SLOT_W-1:0] SLOT_TRI1    = 4'd4;
  localparam logic [SLOT_W-1:0] SLOT_TRI2    = 4'd5;
  localparam logic [SLOT_W-1:0] SLOT_TRI3    = 4'd6;
  localparam logic [SLOT_W-1:0] SLOT_TRI4    = 4'd7;
  localparam logic [SLOT_W-1:0] SLOT_TRI5    = 4'd8;

  // Saturation limits of a normal component
  localparam logic signed [NORM_W-1:0] NORM_MAX = {1'b0, {(NORM_W-1){1'b1}}};
  localparam logic signed [NORM_W-1:0] NORM_MIN = {1'b1, {(NORM_W-1){1'b0}}};

  // Classification of one vertex, front to back
  typedef struct packed {
    logic bank;      // line store bank that this row writes
    logic up;        // normal of the point above is complete
    logic lr_prev;   // last row: normal of the left neighbour
    logic lr_cur;    // last row, last column: normal of this point
    logic quad;      // grid square above-left is complete
    logic last_col;  // vertex sits on the last column
  } gmn_flags_t;

  // One result beat
  typedef struct packed {
    logic                     kind;
    logic [PT_W-1:0]          point_row;
    logic [PT_W-1:0]          point_col;
    logic signed [NORM_W-1:0] norm_x;
    logic signed [NORM_W-1:0] norm_y;
    logic signed [NORM_W-1:0] norm_z;
    logic [IDX_W-1:0]         tri_index;
    logic                     last;
  } gmn_result_t;

endpackage

// ===== rtl/gmn_fifo.sv =====
// ----------------------------------------------------------------------------
// gmn_fifo: small synchronous queue
// Register-based queue with occupancy count; write and read can happen in the same cycle.
// ----------------------------------------------------------------------------
module gmn_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             full_o,
  output logic             empty_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             wr_en, rd_en;

  assign wr_en   = push_i && !full_o;
  assign rd_en   = pop_i && !empty_o;
  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign count_o = count_q;
  assign data_o  = mem_q[rd_ptr_q];

  // Store the incoming beat
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    case ({wr_en, rd_en})
      2'b10:   count_d = count_q + CNT_W'(1);
      2'b01:   count_d = count_q - CNT_W'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== rtl/gmn_front.sv =====
// ----------------------------------------------------------------------------
// gmn_front: configuration registers and vertex classifier
// Tracks the grid position of each accepted vertex, works out which results
// it completes and the row bases of its triangle indices.
// ----------------------------------------------------------------------------
module gmn_front
  import gmn_pkg::*;
#(
  parameter int MAX_ROWS = 1024,
  parameter int MAX_COLS = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [APB_AW-1:0]            paddr,
  input  logic [APB_DW-1:0]            pwdata,
  output logic [APB_DW-1:0]            prdata,
  output logic                         pready,
  // vertex beat accepted this cycle
  input  logic                         accept_i,
  output gmn_flags_t                   flags_o,
  output logic [$clog2(MAX_ROWS)-1:0]  row_o,
  output logic [$clog2(MAX_COLS)-1:0]  col_o,
  output logic [IDX_W-1:0]             base_up_o,
  output logic [IDX_W-1:0]             base_cur_o
);

  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int RCMP_W = ($clog2(MAX_ROWS + 1) > CFG_W) ? $clog2(MAX_ROWS + 1) : CFG_W;
  localparam int CCMP_W = ($clog2(MAX_COLS + 1) > CFG_W) ? $clog2(MAX_COLS + 1) : CFG_W;

  logic [CFG_W-1:0]  grid_rows_q, grid_cols_q;
  logic [RCMP_W-1:0] rows_raw, rows_eff;
  logic [CCMP_W-1:0] cols_raw, cols_eff;
  logic [ROW_W-1:0]  row_last;
  logic [COL_W-1:0]  col_last;
  logic [ROW_W-1:0]  row_q;
  logic [COL_W-1:0]  col_q;
  logic [IDX_W-1:0]  base_up_q, base_cur_q;
  logic              bank_q;
  logic              cfg_wr;
  logic              on_last_row, on_last_col, on_first_col;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // Register read-back
  assign prdata = (paddr[2] == REG_COLS) ? APB_DW'(grid_cols_q) : APB_DW'(grid_rows_q);

  // Clamp the grid size to the supported range
  always_comb begin
    rows_raw = RCMP_W'(grid_rows_q);
    cols_raw = CCMP_W'(grid_cols_q);
    if (rows_raw < RCMP_W'(GRID_MIN)) begin
      rows_eff = RCMP_W'(GRID_MIN);
    end else if (rows_raw > RCMP_W'(MAX_ROWS)) begin
      rows_eff = RCMP_W'(MAX_ROWS);
    end else begin
      rows_eff = rows_raw;
    end
    if (cols_raw < CCMP_W'(GRID_MIN)) begin
      cols_eff = CCMP_W'(GRID_MIN);
    end else if (cols_raw > CCMP_W'(MAX_COLS)) begin
      cols_eff = CCMP_W'(MAX_COLS);
    end else begin
      cols_eff = cols_raw;
    end
    row_last = ROW_W'(rows_eff - RCMP_W'(1));
    col_last = COL_W'(cols_eff - CCMP_W'(1));
  end

  // Classify the vertex at the current position
  assign on_last_row  = (row_q == row_last);
  assign on_last_col  = (col_q == col_last);
  assign on_first_col = (col_q == '0);

  always_comb begin
    flags_o.bank     = bank_q;
    flags_o.up       = (row_q != '0);
    flags_o.lr_prev  = on_last_row && !on_first_col;
    flags_o.lr_cur   = on_last_row && !on_first_col && on_last_col;
    flags_o.quad     = (row_q != '0) && !on_first_col;
    flags_o.last_col = on_last_col;
  end

  assign row_o      = row_q;
  assign col_o      = col_q;
  assign base_up_o  = base_up_q;
  assign base_cur_o = base_cur_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_rows_q <= CFG_W'(GRID_MIN);
      grid_cols_q <= CFG_W'(GRID_MIN);
    end else if (cfg_wr) begin
      if (paddr[2] == REG_COLS) begin
        grid_cols_q <= pwdata[CFG_W-1:0];
      end else begin
        grid_rows_q <= pwdata[CFG_W-1:0];
      end
    end
  end

  // Advance the grid position; any register write restarts the grid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q      <= '0;
      col_q      <= '0;
      base_up_q  <= '0;
      base_cur_q <= '0;
      bank_q     <= 1'b0;
    end else if (cfg_wr) begin
      row_q      <= '0;
      col_q      <= '0;
      base_up_q  <= '0;
      base_cur_q <= '0;
      bank_q     <= 1'b0;
    end else if (accept_i) begin
      if (on_last_col) begin
        col_q  <= '0;
        bank_q <= ~bank_q;
        if (on_last_row) begin
          row_q      <= '0;
          base_up_q  <= '0;
          base_cur_q <= '0;
        end else begin
          row_q      <= row_q + ROW_W'(1);
          base_up_q  <= base_cur_q;
          base_cur_q <= base_cur_q + IDX_W'(cols_eff);
        end
      end else begin
        col_q <= col_q + COL_W'(1);
      end
    end
  end

endmodule

// ===== rtl/gmn_back.sv =====
// ----------------------------------------------------------------------------
// gmn_back: line stores, result sequencer and cross-product pipeline
// Takes classified vertices from the queue, keeps two row banks, walks the
// result slots of each vertex one beat per cycle while the result queue has
// room and computes the normals in a difference / product / combine pipeline.
// ----------------------------------------------------------------------------
module gmn_back
  import gmn_pkg::*;
#(
  parameter int MAX_ROWS   = 1024,
  parameter int MAX_COLS   = 1024,
  parameter int COORD_BITS = 16,
  parameter int OUT_DEPTH  = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // classified vertex queue
  input  logic                             q_empty_i,
  input  gmn_flags_t                       flags_i,
  input  logic [$clog2(MAX_ROWS)-1:0]      row_i,
  input  logic [$clog2(MAX_COLS)-1:0]      col_i,
  input  logic [IDX_W-1:0]                 base_up_i,
  input  logic [IDX_W-1:0]                 base_cur_i,
  input  logic [3*COORD_BITS-1:0]          vert_i,
  output logic                             q_pop_o,
  // result queue
  input  logic [$clog2(OUT_DEPTH+1)-1:0]   out_count_i,
  output logic                             res_valid_o,
  output gmn_result_t                      res_o
);

  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int VW     = 3 * COORD_BITS;
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int MEM_D  = 2 * (1 << COL_W);
  localparam int CNT_W  = $clog2(OUT_DEPTH + 1);

  function automatic logic signed [COORD_BITS-1:0] crd(input logic [VW-1:0] w, input int k);
    return w[k*COORD_BITS +: COORD_BITS];
  endfunction

  // line stores: {bank, column}
  logic [VW-1:0]          line_mem [MEM_D];
  logic [COL_W:0]         wr_addr, rd_a_addr, rd_b_addr;

  // item being sequenced
  logic [NUM_SLOTS-1:0]   mask_q, mask_d, mask_new;
  logic                   last_col_q;
  logic [ROW_W-1:0]       row_q;
  logic [COL_W-1:0]       col_q;
  logic [IDX_W-1:0]       base_up_q, base_cur_q;
  logic [VW-1:0]          v_q, lv_q, pa_q, pb_q, pm1_q;

  // sequencer
  logic [NUM_SLOTS-1:0]   pick;
  logic                   last_pick;
  logic [SLOT_W-1:0]      slot;
  logic [CNT_W:0]         pending;
  logic                   room, issue;
  logic [ROW_W-1:0]       row_m1;
  logic [COL_W-1:0]       col_m1;
  logic                   iss_kind;
  logic [PT_W-1:0]        iss_row, iss_col;
  logic [IDX_W-1:0]       iss_tri;
  logic [VW-1:0]          op_a, op_b, op_c, op_d;

  // pipeline stages
  logic                   s1_v_q, s2_v_q;
  logic                   s1_kind_q, s2_kind_q;
  logic                   s1_last_q, s2_last_q;
  logic [PT_W-1:0]        s1_row_q, s2_row_q, s1_col_q, s2_col_q;
  logic [IDX_W-1:0]       s1_tri_q, s2_tri_q;
  logic signed [DIFF_W-1:0] s1_e1_q [3];
  logic signed [DIFF_W-1:0] s1_e2_q [3];
  logic signed [PROD_W-1:0] s2_p_q [6];
  logic signed [SUM_W-1:0]  sum [3];
  logic signed [NORM_W-1:0] norm [3];

  // Slot mask of the queue head
  always_comb begin
    mask_new = '0;
    mask_new[SLOT_UP]      = flags_i.up;
    mask_new[SLOT_LR_PREV] = flags_i.lr_prev;
    mask_new[SLOT_LR_CUR]  = flags_i.lr_cur;
    for (int i = int'(SLOT_TRI0); i < NUM_SLOTS; i++) begin
      mask_new[i] = flags_i.quad;
    end
  end

  // Pick the lowest pending slot; hold while the result queue has no room
  always_comb begin
    pick      = mask_q & (~mask_q + NUM_SLOTS'(1));
    last_pick = ((mask_q & ~pick) == '0);
    slot      = SLOT_UP;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (pick[i]) begin
        slot = SLOT_W'(i);
      end
    end
    pending = (CNT_W+1)'(out_count_i) + (CNT_W+1)'(s1_v_q) + (CNT_W+1)'(s2_v_q);
    room    = (pending < (CNT_W+1)'(OUT_DEPTH));
    issue   = (mask_q != '0) && room;
    q_pop_o = !q_empty_i && ((mask_q == '0) || (issue && last_pick));
    mask_d  = mask_q;
    if (q_pop_o) begin
      mask_d = mask_new;
    end else if (issue) begin
      mask_d = mask_q & ~pick;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else begin
      mask_q <= mask_d;
    end
  end

  // Line store access: write this row's bank, read the previous row's bank
  assign wr_addr   = {flags_i.bank, col_i};
  assign rd_a_addr = {~flags_i.bank, col_i};
  assign rd_b_addr = {~flags_i.bank, col_i + COL_W'(1)};

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      line_mem[wr_addr] <= vert_i;
      pa_q              <= line_mem[rd_a_addr];
      pb_q              <= line_mem[rd_b_addr];
    end
  end

  // Load the item; carry the left neighbours over from the previous vertex
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      last_col_q <= flags_i.last_col;
      row_q      <= row_i;
      col_q      <= col_i;
      base_up_q  <= base_up_i;
      base_cur_q <= base_cur_i;
      v_q        <= vert_i;
      lv_q       <= v_q;
      pm1_q      <= pa_q;
    end
  end

  // Select operands and indices of the picked slot
  assign row_m1 = row_q - ROW_W'(1);
  assign col_m1 = col_q - COL_W'(1);

  always_comb begin
    iss_kind = KIND_NORMAL;
    iss_row  = '0;
    iss_col  = '0;
    iss_tri  = '0;
    op_a     = v_q;
    op_b     = v_q;
    op_c     = v_q;
    op_d     = v_q;
    case (slot)
      SLOT_UP: begin
        iss_row = PT_W'(row_m1);
        iss_col = PT_W'(col_q);
        if (last_col_q) begin
          op_a = pm1_q;
          op_b = pa_q;
        end else begin
          op_a = pa_q;
          op_b = pb_q;
        end
        op_c = pa_q;
        op_d = v_q;
      end
      SLOT_LR_PREV: begin
        iss_row = PT_W'(row_q);
        iss_col = PT_W'(col_m1);
        op_a    = lv_q;
        op_b    = v_q;
        op_c    = pm1_q;
        op_d    = lv_q;
      end
      SLOT_LR_CUR: begin
        iss_row = PT_W'(row_q);
        iss_col = PT_W'(col_q);
        op_a    = lv_q;
        op_b    = v_q;
        op_c    = pa_q;
        op_d    = v_q;
      end
      SLOT_TRI0: begin
        iss_kind = KIND_INDEX;
        iss_tri  = base_up_q + IDX_W'(col_m1);
      end
      SLOT_TRI1, SLOT_TRI4: begin
        iss_kind = KIND_INDEX;
        iss_tri  = base_up_q + IDX_W'(col_q);
      end
      SLOT_TRI2, SLOT_TRI5: begin
        iss_kind = KIND_INDEX;
        iss_tri  = base_cur_q + IDX_W'(col_m1);
      end
      SLOT_TRI3: begin
        iss_kind = KIND_INDEX;
        iss_tri  = base_cur_q + IDX_W'(col_q);
      end
      default: begin
        iss_kind = KIND_NORMAL;
      end
    endcase
  end

  // Stage 1: edge vectors (zero for index beats)
  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_kind_q <= iss_kind;
      s1_last_q <= last_pick;
      s1_row_q  <= iss_row;
      s1_col_q  <= iss_col;
      s1_tri_q  <= iss_tri;
      for (int k = 0; k < 3; k++) begin
        if (iss_kind == KIND_NORMAL) begin
          s1_e1_q[k] <= DIFF_W'(crd(op_a, k)) - DIFF_W'(crd(op_b, k));
          s1_e2_q[k] <= DIFF_W'(crd(op_c, k)) - DIFF_W'(crd(op_d, k));
        end else begin
          s1_e1_q[k] <= '0;
          s1_e2_q[k] <= '0;
        end
      end
    end
  end

  // Stage 2: cross-product terms
  always_ff @(posedge clk_i) begin
    if (s1_v_q) begin
      s2_kind_q <= s1_kind_q;
      s2_last_q <= s1_last_q;
      s2_row_q  <= s1_row_q;
      s2_col_q  <= s1_col_q;
      s2_tri_q  <= s1_tri_q;
      s2_p_q[0] <= s1_e1_q[1] * s1_e2_q[2];
      s2_p_q[1] <= s1_e1_q[2] * s1_e2_q[1];
      s2_p_q[2] <= s1_e1_q[2] * s1_e2_q[0];
      s2_p_q[3] <= s1_e1_q[0] * s1_e2_q[2];
      s2_p_q[4] <= s1_e1_q[0] * s1_e2_q[1];
      s2_p_q[5] <= s1_e1_q[1] * s1_e2_q[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= issue;
      s2_v_q <= s1_v_q;
    end
  end

  // Combine the terms; saturate to the result width when the sum is wider
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum[k] = SUM_W'(s2_p_q[2*k]) - SUM_W'(s2_p_q[2*k+1]);
    end
  end

  if (SUM_W > NORM_W) begin : g_sat
    always_comb begin
      for (int k = 0; k < 3; k++) begin
        if ((&sum[k][SUM_W-1:NORM_W-1]) || !(|sum[k][SUM_W-1:NORM_W-1])) begin
          norm[k] = sum[k][NORM_W-1:0];
        end else if (sum[k][SUM_W-1]) begin
          norm[k] = NORM_MIN;
        end else begin
          norm[k] = NORM_MAX;
        end
      end
    end
  end else begin : g_ext
    for (genvar k = 0; k < 3; k++) begin : g_comp
      assign norm[k] = NORM_W'(sum[k]);
    end
  end

  // Result beat towards the output queue
  assign res_valid_o = s2_v_q;

  always_comb begin
    res_o.kind      = s2_kind_q;
    res_o.point_row = s2_row_q;
    res_o.point_col = s2_col_q;
    res_o.norm_x    = norm[0];
    res_o.norm_y    = norm[1];
    res_o.norm_z    = norm[2];
    res_o.tri_index = s2_tri_q;
    res_o.last      = s2_last_q;
  end

endmodule

// ===== rtl/grid_mesh_normal_index_gen_unit.sv =====
// ----------------------------------------------------------------------------
// grid_mesh_normal_index_gen_unit: grid mesh normal and triangle index generator
// A vertex passes the vertex queue, the slot sequencer, the edge and product
// stages and the result queue; its results leave the slot sequencer one per
// cycle while the result queue has room. A vertex of row 0 yields no result,
// an interior vertex up to 7 and a last-row vertex up to 9.
// Reset: counters, queues and registers (both sizes 2) clear; line stores do not.
// ----------------------------------------------------------------------------
module grid_mesh_normal_index_gen_unit
  import gmn_pkg::*;
#(
  parameter int MAX_ROWS   = 1024,
  parameter int MAX_COLS   = 1024,
  parameter int COORD_BITS = 16,
  parameter int IN_DEPTH   = 4,
  parameter int OUT_DEPTH  = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [APB_AW-1:0]            paddr,
  input  logic [APB_DW-1:0]            pwdata,
  output logic [APB_DW-1:0]            prdata,
  output logic                         pready,
  // vertex input
  input  logic                         push,
  output logic                         full,
  input  logic signed [COORD_BITS-1:0] vert_x_i,
  input  logic signed [COORD_BITS-1:0] vert_y_i,
  input  logic signed [COORD_BITS-1:0] vert_z_i,
  // result output
  output logic                         empty,
  input  logic                         pop,
  output logic                         kind_o,
  output logic [PT_W-1:0]              point_row_o,
  output logic [PT_W-1:0]              point_col_o,
  output logic signed [NORM_W-1:0]     norm_x_o,
  output logic signed [NORM_W-1:0]     norm_y_o,
  output logic signed [NORM_W-1:0]     norm_z_o,
  output logic [IDX_W-1:0]             tri_index_o,
  output logic                         last_o
);

  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int COL_W = $clog2(MAX_COLS);
  localparam int VW    = 3 * COORD_BITS;
  localparam int FL_W  = $bits(gmn_flags_t);
  localparam int IQ_W  = FL_W + ROW_W + COL_W + 2 * IDX_W + VW;
  localparam int RES_W = $bits(gmn_result_t);

  gmn_flags_t        fr_flags, bk_flags;
  logic [ROW_W-1:0]  fr_row, bk_row;
  logic [COL_W-1:0]  fr_col, bk_col;
  logic [IDX_W-1:0]  fr_base_up, fr_base_cur, bk_base_up, bk_base_cur;
  logic [VW-1:0]     bk_vert;
  logic              in_accept;
  logic [IQ_W-1:0]   iq_wdata, iq_rdata;
  logic              iq_empty, iq_pop;
  logic [$clog2(IN_DEPTH+1)-1:0]  iq_count;
  logic              res_valid, out_full;
  gmn_result_t       res_beat, out_beat;
  logic [RES_W-1:0]  out_rdata;
  logic [$clog2(OUT_DEPTH+1)-1:0] out_count;

  assign in_accept = push && !full;

  // Front: registers and classification
  gmn_front #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .accept_i   (in_accept),
    .flags_o    (fr_flags),
    .row_o      (fr_row),
    .col_o      (fr_col),
    .base_up_o  (fr_base_up),
    .base_cur_o (fr_base_cur)
  );

  // Queue between front and back
  assign iq_wdata = {fr_flags, fr_row, fr_col, fr_base_up, fr_base_cur,
                     vert_z_i, vert_y_i, vert_x_i};

  gmn_fifo #(
    .WIDTH (IQ_W),
    .DEPTH (IN_DEPTH)
  ) u_in_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (iq_wdata),
    .pop_i   (iq_pop),
    .data_o  (iq_rdata),
    .full_o  (full),
    .empty_o (iq_empty),
    .count_o (iq_count)
  );

  assign {bk_flags, bk_row, bk_col, bk_base_up, bk_base_cur, bk_vert} = iq_rdata;

  // Back: line stores and result generation
  gmn_back #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .COORD_BITS (COORD_BITS),
    .OUT_DEPTH  (OUT_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (iq_empty),
    .flags_i     (bk_flags),
    .row_i       (bk_row),
    .col_i       (bk_col),
    .base_up_i   (bk_base_up),
    .base_cur_i  (bk_base_cur),
    .vert_i      (bk_vert),
    .q_pop_o     (iq_pop),
    .out_count_i (out_count),
    .res_valid_o (res_valid),
    .res_o       (res_beat)
  );

  // Result queue
  gmn_fifo #(
    .WIDTH (RES_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res_beat),
    .pop_i   (pop),
    .data_o  (out_rdata),
    .full_o  (out_full),
    .empty_o (empty),
    .count_o (out_count)
  );

  assign out_beat    = out_rdata;
  assign kind_o      = out_beat.kind;
  assign point_row_o = out_beat.point_row;
  assign point_col_o = out_beat.point_col;
  assign norm_x_o    = out_beat.norm_x;
  assign norm_y_o    = out_beat.norm_y;
  assign norm_z_o    = out_beat.norm_z;
  assign tri_index_o = out_beat.tri_index;
  assign last_o      = out_beat.last;

  // Checks
  a_out_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> !out_full)
    else $error("result beat arrived at a full result queue");

  a_pop_non_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    iq_pop |-> !iq_empty)
    else $error("back end popped an empty vertex queue");

  a_quad_needs_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && fr_flags.quad) |-> fr_flags.up)
    else $error("grid square classified on the first row");

  a_corner_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && fr_flags.lr_cur) |-> (fr_flags.lr_prev && fr_flags.last_col))
    else $error("corner normal classified off the last column");

  a_queue_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> (iq_count != '0))
    else $error("vertex queue reports full with no entries");

endmodule
